// ----- hw/rtl/slq_pkg.sv -----
`default_nettype none

package slq_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [2:0] CMD_PUSH_FRONT    = 3'd0;
    localparam logic [2:0] CMD_INSERT_SORTED = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT     = 3'd2;
    localparam logic [2:0] CMD_SEARCH        = 3'd3;
    localparam logic [2:0] CMD_COUNT         = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Slot of the idx-th entry counted from the head, circular buffer.
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [ADDR_W-1:0] idx);
        logic [ADDR_W:0] sum;
        sum = (ADDR_W+1)'(head) + (ADDR_W+1)'(idx);
        if (sum >= (ADDR_W+1)'(CAPACITY)) begin
            sum = sum - (ADDR_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] prev_addr(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] res;
        if (head == '0) begin
            res = ADDR_W'(CAPACITY - 1);
        end else begin
            res = head - ADDR_W'(1);
        end
        return res;
    endfunction

    function automatic logic [3:0] low4(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[3:0];
    endfunction

    function automatic logic [4:0] low5(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[4:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/slq_ram.sv -----
`default_nettype none

module slq_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [DATA_W-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [DATA_W-1:0]                           rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_list_queue.sv -----
// sorted_list_queue: bounded list of signed 32-bit values, head first.
// Input channel s_valid/s_ready carries a request: s_cmd and s_value.
// Result channel m_valid/m_ready returns one result per request: m_status,
// m_data, m_position and m_entries_held (count after the request).
// Entries sit in a circular buffer in one synchronous RAM (one write port,
// one read port, registered read). push_front, count and requests refused
// at once (full insert, empty pop, search of an empty list) finish without
// a RAM walk. pop_front reads the head entry. search streams the list
// through the read port, one entry per cycle. insert_sorted walks the
// whole list, reading one entry each cycle and, from the insert point on,
// writing the shifted one back, then writes the tail slot. The block is
// ready for the next request as soon as the previous result is loaded
// into the output register, so a result that waits for m_ready does not
// block the next request until the block has another result ready. A
// stalled receiver holds the result register.
// Reset (aresetn low, synchronous) empties the list; RAM contents are
// not cleared and are never read before being written.
`default_nettype none

module sorted_list_queue import slq_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_data,
    output logic [3:0]              m_position,
    output logic [4:0]              m_entries_held
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [2:0]               cmd_reg, cmd_next;
    logic signed [31:0]       value_reg, value_next;
    logic [ADDR_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic                     placed_reg, placed_next;
    logic [DATA_W-1:0]        carry_reg, carry_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic signed [31:0]       res_data_reg, res_data_next;
    logic [CNT_W-1:0]         res_pos_reg, res_pos_next;
    logic                     m_valid_reg, m_valid_next;
    logic [1:0]               m_status_reg, m_status_next;
    logic signed [31:0]       m_data_reg, m_data_next;
    logic [3:0]               m_position_reg, m_position_next;
    logic [4:0]               m_entries_held_reg, m_entries_held_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic [CNT_W-1:0]         scan_limit;
    logic                     last_rd;
    logic                     full;

    slq_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_limit = (cmd_reg == CMD_POP_FRONT) ? CNT_W'(1) : count_reg;
    assign last_rd    = (rd_idx_reg + CNT_W'(1)) == scan_limit;
    assign full       = (count_reg == CAP_CNT);

    always_comb begin
        state_next          = state_reg;
        cmd_next            = cmd_reg;
        value_next          = value_reg;
        head_next           = head_reg;
        count_next          = count_reg;
        idx_next            = idx_reg;
        rd_idx_next         = rd_idx_reg;
        rd_pend_next        = rd_pend_reg;
        placed_next         = placed_reg;
        carry_next          = carry_reg;
        res_status_next     = res_status_reg;
        res_data_next       = res_data_reg;
        res_pos_next        = res_pos_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_status_next       = m_status_reg;
        m_data_next         = m_data_reg;
        m_position_next     = m_position_reg;
        m_entries_held_next = m_entries_held_reg;
        s_ready             = 1'b0;
        ram_we              = 1'b0;
        ram_waddr           = head_reg;
        ram_wdata           = value_reg;
        ram_raddr           = phys_addr(head_reg, idx_reg[ADDR_W-1:0]);

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next        = s_cmd;
                    value_next      = s_value;
                    idx_next        = '0;
                    rd_pend_next    = 1'b0;
                    placed_next     = 1'b0;
                    res_status_next = ST_OK;
                    res_data_next   = '0;
                    res_pos_next    = '0;
                    state_next      = S_FIN;
                    case (s_cmd)
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                head_next  = prev_addr(head_reg);
                                ram_we     = 1'b1;
                                ram_waddr  = prev_addr(head_reg);
                                ram_wdata  = s_value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_INSERT_SORTED: begin
                            if (full) begin
                                res_status_next = ST_FULL;
                            end else if (count_reg == '0) begin
                                state_next = S_TAIL;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_SEARCH: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_NOT_FOUND;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // read of entry idx is issued here, its data arrives next cycle
                if (idx_reg < scan_limit) begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = idx_reg;
                    idx_next     = idx_reg + CNT_W'(1);
                end else begin
                    rd_pend_next = 1'b0;
                end
                if (rd_pend_reg) begin
                    case (cmd_reg)
                        CMD_POP_FRONT: begin
                            res_data_next = ram_rdata;
                            head_next     = phys_addr(head_reg, ADDR_W'(1));
                            count_next    = count_reg - CNT_W'(1);
                            state_next    = S_FIN;
                        end
                        CMD_SEARCH: begin
                            if (ram_rdata == value_reg) begin
                                res_data_next = value_reg;
                                res_pos_next  = rd_idx_reg;
                                state_next    = S_FIN;
                            end else if (last_rd) begin
                                res_status_next = ST_NOT_FOUND;
                                state_next      = S_FIN;
                            end
                        end
                        default: begin
                            // insert: once placed, every later entry moves one slot down
                            ram_waddr = phys_addr(head_reg, rd_idx_reg[ADDR_W-1:0]);
                            if (placed_reg) begin
                                ram_we     = 1'b1;
                                ram_wdata  = carry_reg;
                                carry_next = ram_rdata;
                            end else if ($signed(ram_rdata) >= value_reg) begin
                                ram_we      = 1'b1;
                                ram_wdata   = value_reg;
                                carry_next  = ram_rdata;
                                placed_next = 1'b1;
                            end
                            if (last_rd) begin
                                state_next = S_TAIL;
                            end
                        end
                    endcase
                end
            end

            S_TAIL: begin
                ram_we     = 1'b1;
                ram_waddr  = phys_addr(head_reg, count_reg[ADDR_W-1:0]);
                ram_wdata  = placed_reg ? carry_reg : value_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_FIN;
            end

            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_status_next       = res_status_reg;
                    m_data_next         = res_data_reg;
                    m_position_next     = low4(res_pos_reg);
                    m_entries_held_next = low5(count_reg);
                    state_next          = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg            <= cmd_next;
        value_reg          <= value_next;
        idx_reg            <= idx_next;
        rd_idx_reg         <= rd_idx_next;
        placed_reg         <= placed_next;
        carry_reg          <= carry_next;
        res_status_reg     <= res_status_next;
        res_data_reg       <= res_data_next;
        res_pos_reg        <= res_pos_next;
        m_status_reg       <= m_status_next;
        m_data_reg         <= m_data_next;
        m_position_reg     <= m_position_next;
        m_entries_held_reg <= m_entries_held_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_data         = m_data_reg;
    assign m_position     = m_position_reg;
    assign m_entries_held = m_entries_held_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == CMD_PUSH_FRONT && !full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push_front did not add an entry");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> m_entries_held == 5'd0)
        else $error("empty status with entries held");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> m_entries_held == low5(CAP_CNT))
        else $error("full status while list not full");

endmodule

`default_nettype wire

// ----- test/sorted_list_queue_tb.sv -----
`timescale 1ns / 1ps

module sorted_list_queue_tb;
    import slq_pkg::*;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [3:0]         position;
        logic [4:0]         entries;
    } list_reply_t;

    class list_checker;
        logic signed [31:0] shadow_list [CAPACITY];
        int unsigned        shadow_count;
        list_reply_t        due_replies[$];
        int                 errors;

        function new();
            shadow_count = 0;
            errors = 0;
        endfunction

        // Update the shadow list for one accepted request and queue its reply.
        function void note_request(input logic [2:0] cmd, input logic signed [31:0] value);
            list_reply_t r;
            int unsigned pos;
            int          i;
            bit          found;
            r.status = ST_OK;
            r.data = '0;
            r.position = '0;
            found = 1'b0;
            pos = 0;
            case (cmd)
                CMD_PUSH_FRONT, CMD_INSERT_SORTED: begin
                    if (shadow_count >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        // equal values go ahead of older equals
                        if (cmd == CMD_INSERT_SORTED) begin
                            while (pos < shadow_count && shadow_list[pos] < value) begin
                                pos++;
                            end
                        end
                        for (i = shadow_count; i > pos; i--) begin
                            shadow_list[i] = shadow_list[i-1];
                        end
                        shadow_list[pos] = value;
                        shadow_count++;
                    end
                end
                CMD_POP_FRONT: begin
                    if (shadow_count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.data = shadow_list[0];
                        for (i = 1; i < shadow_count; i++) begin
                            shadow_list[i-1] = shadow_list[i];
                        end
                        shadow_count--;
                    end
                end
                CMD_SEARCH: begin
                    for (i = 0; i < shadow_count; i++) begin
                        if (!found && shadow_list[i] == value) begin
                            found = 1'b1;
                            pos = i;
                        end
                    end
                    if (found) begin
                        r.data = value;
                        r.position = pos[3:0];
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                default: ; // count and undefined codes only report
            endcase
            r.entries = shadow_count[4:0];
            due_replies.push_back(r);
        endfunction

        function void check_reply(input logic [1:0] status, input logic signed [31:0] data,
                                  input logic [3:0] position, input logic [4:0] entries);
            list_reply_t e;
            if (due_replies.size() == 0) begin
                $display("%0t: reply with none outstanding: status %0d data %0d pos %0d cnt %0d",
                         $realtime, status, data, position, entries);
                errors++;
                return;
            end
            e = due_replies.pop_front();
            if (status !== e.status) begin
                $display("%0t: status expected %0d got %0d", $realtime, e.status, status);
                errors++;
            end
            if (data !== e.data) begin
                $display("%0t: data expected %0d got %0d", $realtime, e.data, data);
                errors++;
            end
            if (position !== e.position) begin
                $display("%0t: position expected %0d got %0d", $realtime, e.position, position);
                errors++;
            end
            if (entries !== e.entries) begin
                $display("%0t: entries_held expected %0d got %0d", $realtime, e.entries, entries);
                errors++;
            end
        endfunction

        function logic signed [31:0] pick_held();
            if (shadow_count == 0) begin
                return $urandom;
            end
            return shadow_list[$urandom_range(0, shadow_count - 1)];
        endfunction
    endclass

    localparam int NUM_RANDOM = 1250;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_cmd = '0;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic signed [31:0] m_data;
    logic [3:0]         m_position;
    logic [4:0]         m_entries_held;

    list_checker chk = new();

    bit tx_free = 1'b0;
    bit rx_free = 1'b0;
    int rx_left = 0;
    bit rx_state = 1'b0;
    int sent = 0;

    sorted_list_queue dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_data         (m_data),
        .m_position     (m_position),
        .m_entries_held (m_entries_held)
    );

    always #5 aclk = ~aclk;

    // Receiver back-pressure: ready runs and stall runs, mostly short.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            if (rx_free || $urandom_range(0, 99) < 65) begin
                rx_state = 1'b1;
                rx_left = $urandom_range(1, 24);
            end else begin
                rx_state = 1'b0;
                rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(1, 3);
            end
        end
        rx_left--;
        m_ready <= rx_state;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            chk.check_reply(m_status, m_data, m_position, m_entries_held);
        end
    end

    // Called at a falling edge; returns at a falling edge with s_valid still high.
    task automatic issue_request(input logic [2:0] cmd, input logic signed [31:0] value);
        int gap;
        gap = 0;
        if (!tx_free && $urandom_range(0, 99) < 40) begin
            gap = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_value <= value;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        chk.note_request(cmd, value);
        sent++;
        @(negedge aclk);
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        while (chk.due_replies.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    function automatic logic signed [31:0] rand_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) begin
            return $signed($urandom_range(0, 15)) - 8;
        end
        if (k == 4) begin
            case ($urandom_range(0, 5))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh8000_0001;
                3: return 32'sh7fff_fffe;
                4: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_phase(input int mode, input int len);
        int          n;
        int          r;
        logic [2:0]  cmd;
        logic signed [31:0] value;
        for (n = 0; n < len; n++) begin
            r = $urandom_range(0, 99);
            // modes: 0 fill-heavy, 1 drain-heavy, 2 mixed, 3 noise
            if (mode == 3) begin
                cmd = 3'($urandom_range(0, 7));
            end else if (r < (mode == 0 ? 40 : mode == 1 ? 15 : 30)) begin
                cmd = CMD_INSERT_SORTED;
            end else if (r < (mode == 0 ? 65 : mode == 1 ? 25 : 45)) begin
                cmd = CMD_PUSH_FRONT;
            end else if (r < (mode == 0 ? 75 : mode == 1 ? 65 : 70)) begin
                cmd = CMD_POP_FRONT;
            end else if (r < (mode == 0 ? 92 : mode == 1 ? 88 : 92)) begin
                cmd = CMD_SEARCH;
            end else if (r < 96) begin
                cmd = CMD_COUNT;
            end else begin
                cmd = 3'($urandom_range(5, 7));
            end
            if (mode != 3 && cmd == CMD_SEARCH && $urandom_range(0, 99) < 65) begin
                value = chk.pick_held();
            end else if (mode == 3) begin
                value = $urandom;
            end else begin
                value = rand_value();
            end
            issue_request(cmd, value);
        end
    endtask

    initial begin
        int i;
        int target;
        int len;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty list cases, undefined codes, extremes, full list
        issue_request(CMD_COUNT, 0);
        issue_request(CMD_POP_FRONT, 32'sh7fff_ffff);
        issue_request(CMD_SEARCH, 0);
        issue_request(3'd5, -1);
        issue_request(3'd6, 32'sh8000_0000);
        issue_request(3'd7, 32'sh7fff_ffff);
        issue_request(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        issue_request(CMD_PUSH_FRONT, 32'sh8000_0000);
        issue_request(CMD_INSERT_SORTED, 0);
        issue_request(CMD_INSERT_SORTED, -1);
        issue_request(CMD_INSERT_SORTED, 32'sh7fff_ffff);
        issue_request(CMD_INSERT_SORTED, 32'sh8000_0000);
        issue_request(CMD_SEARCH, 32'sh7fff_ffff);
        issue_request(CMD_SEARCH, 1);
        for (i = 0; i < CAPACITY - 6; i++) begin
            issue_request(CMD_PUSH_FRONT, i * 3 - 7);
        end
        issue_request(CMD_PUSH_FRONT, 5);
        issue_request(CMD_INSERT_SORTED, 5);
        issue_request(CMD_POP_FRONT, 0);
        drain_replies();

        target = sent + NUM_RANDOM;
        while (sent < target) begin
            tx_free = ($urandom_range(0, 3) == 0);
            rx_free = ($urandom_range(0, 3) == 0);
            len = $urandom_range(30, 120);
            if (len > target - sent) begin
                len = target - sent;
            end
            random_phase($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2), len);
            if ($urandom_range(0, 1) == 0) begin
                drain_replies();
            end
        end
        tx_free = 1'b0;
        rx_free = 1'b0;
        drain_replies();
        repeat (50) @(posedge aclk);

        if (chk.errors == 0 && chk.due_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
